>>> hw/rtl/maq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mail address quoter package
// Shared types, byte constants, character classes and the microcode ROM.
// ----------------------------------------------------------------------------
package maq_pkg;

   // Default number of address bytes kept in the buffer.
   localparam int MAX_LEN_DEF = 31;

   // Byte values that the quoter recognizes or produces.
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_LT        = 8'h3C;
   localparam logic [7:0] CH_GT        = 8'h3E;
   localparam logic [7:0] CH_LPAREN    = 8'h28;
   localparam logic [7:0] CH_RPAREN    = 8'h29;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0D;

   // Payload of one input item.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_payload_type;

   // Payload of one result item.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       was_quoted;
      logic       overflowed;
   } rsp_payload_type;

   // Microprogram step addresses.
   typedef enum logic [3:0] {
      STEP_COLLECT,
      STEP_FETCH,
      STEP_OPEN,
      STEP_CHECK,
      STEP_ESCAPE,
      STEP_DATA,
      STEP_TAIL,
      STEP_CLOSE,
      STEP_FINISH
   } step_type;

   // Jump conditions tested by the sequencer.
   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_ACC_LAST,
      COND_QUOTED,
      COND_ESCAPE,
      COND_AT_END
   } cond_type;

   // Source of the byte loaded into the output register.
   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_QUOTE,
      EMIT_BACKSLASH,
      EMIT_DATA
   } emit_type;

   // One control word of the microprogram.
   typedef struct packed {
      logic     take_req;
      logic     rd_start;
      logic     advance;
      logic     clear;
      emit_type emit;
      logic     close;
      cond_type cond;
      step_type jump_t;
      step_type jump_f;
   } ctrl_type;

   // Datapath status seen by the sequencer.
   typedef struct packed {
      logic acc_last;
      logic quoted;
      logic escape;
      logic at_end;
      logic slot_free;
   } status_type;

   // Bytes that must be escaped inside a quoted address.
   function automatic logic is_special(input logic [7:0] c);
      return c inside {CH_QUOTE, CH_BACKSLASH, CH_LT, CH_GT, CH_LPAREN, CH_RPAREN};
   endfunction

   // Whitespace in the sense of the C isspace class.
   function automatic logic is_white(input logic [7:0] c);
      return c inside {CH_SPACE, [CH_TAB:CH_CR]};
   endfunction

   // Microcode ROM: one control word per step.
   function automatic ctrl_type ucode_rom(input step_type s);
      ctrl_type w;
      w.take_req = 1'b0;
      w.rd_start = 1'b0;
      w.advance  = 1'b0;
      w.clear    = 1'b0;
      w.emit     = EMIT_NONE;
      w.close    = 1'b0;
      w.cond     = COND_ALWAYS;
      w.jump_t   = STEP_COLLECT;
      w.jump_f   = STEP_COLLECT;
      case (s)
         STEP_COLLECT: begin
            w.take_req = 1'b1;
            w.cond     = COND_ACC_LAST;
            w.jump_t   = STEP_FETCH;
            w.jump_f   = STEP_COLLECT;
         end
         STEP_FETCH: begin
            w.rd_start = 1'b1;
            w.cond     = COND_QUOTED;
            w.jump_t   = STEP_OPEN;
            w.jump_f   = STEP_CHECK;
         end
         STEP_OPEN: begin
            w.emit   = EMIT_QUOTE;
            w.jump_t = STEP_CHECK;
         end
         STEP_CHECK: begin
            w.cond   = COND_ESCAPE;
            w.jump_t = STEP_ESCAPE;
            w.jump_f = STEP_DATA;
         end
         STEP_ESCAPE: begin
            w.emit   = EMIT_BACKSLASH;
            w.jump_t = STEP_DATA;
         end
         STEP_DATA: begin
            w.emit    = EMIT_DATA;
            w.advance = 1'b1;
            w.cond    = COND_AT_END;
            w.jump_t  = STEP_TAIL;
            w.jump_f  = STEP_CHECK;
         end
         STEP_TAIL: begin
            w.cond   = COND_QUOTED;
            w.jump_t = STEP_CLOSE;
            w.jump_f = STEP_FINISH;
         end
         STEP_CLOSE: begin
            w.emit   = EMIT_QUOTE;
            w.close  = 1'b1;
            w.jump_t = STEP_FINISH;
         end
         STEP_FINISH: begin
            w.clear  = 1'b1;
            w.jump_t = STEP_COLLECT;
         end
         default: begin
            w.clear  = 1'b1;
            w.jump_t = STEP_COLLECT;
         end
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/maq_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mail address quoter stream interface
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface maq_stream_if #(
   parameter type payload_type = logic [7:0]
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface
`default_nettype wire

>>> hw/rtl/maq_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mail address quoter sequencer
// Step counter over the microcode ROM with conditional jumps and stall hold.
// ----------------------------------------------------------------------------
module maq_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  maq_pkg::status_type status,
   output maq_pkg::ctrl_type   ctrl
);
   import maq_pkg::*;

   step_type step_ff;
   step_type step_in;
   ctrl_type word;
   logic     hold;
   logic     cond_true;

   // Fetch the control word and decide whether the output slot stalls it.
   always_comb begin
      word = ucode_rom(step_ff);
      hold = (word.emit != EMIT_NONE) && !status.slot_free;
   end

   // Evaluate the jump condition of the current word.
   always_comb begin
      case (word.cond)
         COND_ALWAYS:   cond_true = 1'b1;
         COND_ACC_LAST: cond_true = status.acc_last;
         COND_QUOTED:   cond_true = status.quoted;
         COND_ESCAPE:   cond_true = status.escape;
         COND_AT_END:   cond_true = status.at_end;
         default:       cond_true = 1'b1;
      endcase
   end

   // Next step: hold on a stall, otherwise take the selected jump.
   always_comb begin
      if (hold) begin
         step_in = step_ff;
      end else if (cond_true) begin
         step_in = word.jump_t;
      end else begin
         step_in = word.jump_f;
      end
   end

   // Control outputs: a stalled step performs no datapath action.
   always_comb begin
      ctrl = word;
      if (hold) begin
         ctrl.emit    = EMIT_NONE;
         ctrl.advance = 1'b0;
         ctrl.close   = 1'b0;
      end
   end

   // Step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_COLLECT;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/maq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mail address quoter datapath
// Address buffer, byte count, quoting and overflow flags, and output register.
// ----------------------------------------------------------------------------
module maq_datapath #(
   parameter int MAX_LEN = maq_pkg::MAX_LEN_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  maq_pkg::ctrl_type   ctrl,
   output maq_pkg::status_type status,
   maq_stream_if.sink          req,
   maq_stream_if.source        rsp
);
   import maq_pkg::*;

   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_LEN);

   logic [7:0]       mem [MAX_LEN];
   logic [CNT_W-1:0] count_ff, count_in;
   logic             quoted_ff, quoted_in;
   logic             over_ff, over_in;
   logic [CNT_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] ptr_next;
   logic [7:0]       rd_data_ff;
   logic             rd_en;
   logic [CNT_W-1:0] rd_addr;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_pl_ff, rsp_pl_in;
   logic             accept;
   logic             is_full;
   logic             at_end;
   logic [7:0]       in_b;

   assign in_b     = req.payload.in_byte;
   assign accept   = req.valid && ctrl.take_req;
   assign is_full  = (count_ff == FULL);
   assign ptr_next = rd_ptr_ff + CNT_W'(1);
   assign at_end   = (ptr_next == count_ff);

   // Handshake and status toward the sequencer.
   assign req.ready        = ctrl.take_req;
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.payload      = rsp_pl_ff;
   assign status.acc_last  = accept && req.payload.in_last;
   assign status.quoted    = quoted_ff;
   assign status.escape    = quoted_ff && is_special(rd_data_ff);
   assign status.at_end    = at_end;
   assign status.slot_free = !rsp_valid_ff || rsp.ready;

   // Count and flags while collecting; cleared at the end of a run.
   always_comb begin
      count_in  = count_ff;
      quoted_in = quoted_ff;
      over_in   = over_ff;
      rd_ptr_in = rd_ptr_ff;
      if (ctrl.clear) begin
         count_in  = '0;
         quoted_in = 1'b0;
         over_in   = 1'b0;
         rd_ptr_in = '0;
      end else begin
         if (accept) begin
            if (is_full) begin
               over_in = 1'b1;
            end else begin
               count_in = count_ff + CNT_W'(1);
               if (is_special(in_b) || is_white(in_b)) begin
                  quoted_in = 1'b1;
               end
            end
         end
         if (ctrl.advance) begin
            rd_ptr_in = ptr_next;
         end
      end
   end

   // Buffer read address: first entry on start, the next entry on advance.
   always_comb begin
      rd_en   = ctrl.rd_start || (ctrl.advance && !at_end);
      rd_addr = ctrl.rd_start ? rd_ptr_ff : ptr_next;
   end

   // Output register load.
   always_comb begin
      rsp_pl_in = rsp_pl_ff;
      if (ctrl.emit != EMIT_NONE) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      case (ctrl.emit)
         EMIT_QUOTE:     rsp_pl_in.out_byte = CH_QUOTE;
         EMIT_BACKSLASH: rsp_pl_in.out_byte = CH_BACKSLASH;
         EMIT_DATA:      rsp_pl_in.out_byte = rd_data_ff;
         default:        rsp_pl_in.out_byte = rsp_pl_ff.out_byte;
      endcase
      if (ctrl.emit != EMIT_NONE) begin
         rsp_pl_in.out_last   = ctrl.close ||
                                ((ctrl.emit == EMIT_DATA) && !quoted_ff && at_end);
         rsp_pl_in.was_quoted = quoted_ff;
         rsp_pl_in.overflowed = over_ff;
      end
   end

   // Address buffer: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (accept && !is_full) begin
         mem[count_ff[IDX_W-1:0]] <= in_b;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr[IDX_W-1:0]];
      end
   end

   // Payload register.
   always_ff @(posedge clock) begin
      rsp_pl_ff <= rsp_pl_in;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         quoted_ff    <= 1'b0;
         over_ff      <= 1'b0;
         rd_ptr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         quoted_ff    <= quoted_in;
         over_ff      <= over_in;
         rd_ptr_ff    <= rd_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A dropped byte can only happen once the buffer is full.
   a_over_full: assert property (@(posedge clock) disable iff (reset)
      over_ff |-> (count_ff == FULL))
      else $error("overflow flag set while buffer not full");

   // The read pointer never passes the number of kept bytes.
   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      rd_ptr_ff <= count_ff)
      else $error("read pointer beyond kept bytes");

   // Items are only taken while no run is being read out.
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      accept |-> (rd_ptr_ff == '0))
      else $error("input item accepted during emission");

   // The final byte of a quoted run is the closing quote.
   a_close_quote: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_pl_ff.out_last && rsp_pl_ff.was_quoted)
         |-> (rsp_pl_ff.out_byte == CH_QUOTE))
      else $error("quoted run does not end in a quote");

endmodule
`default_nettype wire

>>> hw/rtl/mail_address_quoter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mail address quoter
// Buffers a mail address and emits it raw or as an escaped quoted string.
// ----------------------------------------------------------------------------
// Each non-final address byte is accepted while the block collects. On the
// byte marked last the block stops accepting and plays the buffered address
// out, one byte per result item: a buffer fetch step, then the opening quote
// if quoted, a check step and a data step per kept byte with an escape step
// before each escaped byte, then the tail check, the closing quote if quoted
// and the final clear; the result side can stall any step that emits a byte.
// This order comes from the step sequence of the microcode ROM and the
// single registered read port of the address buffer.
// Only the first MAX_LEN bytes of an address are kept; later bytes are
// dropped and every result of that run carries the overflowed flag.
// ----------------------------------------------------------------------------
module mail_address_quoter #(
   parameter int MAX_LEN = maq_pkg::MAX_LEN_DEF
) (
   input  logic         clock,
   input  logic         reset,
   maq_stream_if.sink   req,
   maq_stream_if.source rsp
);
   import maq_pkg::*;

   ctrl_type   ctrl;
   status_type status;

   // Microcode step counter and ROM.
   maq_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // Buffer, flags and output register.
   maq_datapath #(
      .MAX_LEN (MAX_LEN)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .status (status),
      .req    (req),
      .rsp    (rsp)
   );

endmodule
`default_nettype wire

>>> dv/maq_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mail address quoter result checker
// Follows every accepted address byte, works out the bytes that the quoter
// must return for each address and compares them, in order and field by
// field, with the accepted result items.
// ----------------------------------------------------------------------------
module maq_result_checker #(
   parameter int ADDR_CAP = maq_pkg::MAX_LEN_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  maq_pkg::req_payload_type req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  maq_pkg::rsp_payload_type rsp_payload,
   output int                       mismatch_count,
   output int                       results_pending
);
   import maq_pkg::*;

   // Shadow of the address buffer and its flags.
   logic [7:0]      addr_kept [ADDR_CAP];
   int              kept_len;
   logic            quote_due;
   logic            bytes_dropped;
   rsp_payload_type quoted_bytes_due [$];
   int              errors;

   initial begin
      mismatch_count  = 0;
      results_pending = 0;
      errors          = 0;
      kept_len        = 0;
      quote_due       = 1'b0;
      bytes_dropped   = 1'b0;
   end

   // Bytes that get a backslash in front of them inside quotes.
   function automatic logic must_escape(input logic [7:0] c);
      case (c)
         CH_QUOTE, CH_BACKSLASH, CH_LT, CH_GT, CH_LPAREN, CH_RPAREN: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // Space plus the control range from tab to carriage return.
   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

   // Queue one expected output byte with the flags of the current address.
   task automatic push_result(input logic [7:0] b);
      rsp_payload_type r;
      r.out_byte   = b;
      r.out_last   = 1'b0;
      r.was_quoted = quote_due;
      r.overflowed = bytes_dropped;
      quoted_bytes_due.push_back(r);
   endtask

   // Keep or drop one address byte; on the last one, expand the address.
   task automatic take_address_byte(input logic [7:0] b, input logic is_last);
      rsp_payload_type r;
      if (kept_len < ADDR_CAP) begin
         addr_kept[kept_len] = b;
         kept_len++;
         if (must_escape(b) || is_blank(b)) begin
            quote_due = 1'b1;
         end
      end else begin
         bytes_dropped = 1'b1;
      end
      if (is_last) begin
         if (quote_due) begin
            push_result(CH_QUOTE);
         end
         for (int i = 0; i < kept_len; i++) begin
            if (quote_due && must_escape(addr_kept[i])) begin
               push_result(CH_BACKSLASH);
            end
            push_result(addr_kept[i]);
         end
         if (quote_due) begin
            push_result(CH_QUOTE);
         end
         // The final byte of the run carries the last marker.
         r = quoted_bytes_due.pop_back();
         r.out_last = 1'b1;
         quoted_bytes_due.push_back(r);
         kept_len      = 0;
         quote_due     = 1'b0;
         bytes_dropped = 1'b0;
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endtask

   // Predict on accepted address bytes, compare on accepted result items.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         kept_len      = 0;
         quote_due     = 1'b0;
         bytes_dropped = 1'b0;
         quoted_bytes_due.delete();
      end else begin
         if (req_valid && req_ready) begin
            take_address_byte(req_payload.in_byte, req_payload.in_last);
         end
         if (rsp_valid && rsp_ready) begin
            if (quoted_bytes_due.size() == 0) begin
               $error("result item with nothing expected: out_byte %0h",
                      rsp_payload.out_byte);
               errors++;
            end else begin
               want = quoted_bytes_due.pop_front();
               check_field("out_byte", want.out_byte, rsp_payload.out_byte);
               check_field("out_last", 8'(want.out_last), 8'(rsp_payload.out_last));
               check_field("was_quoted", 8'(want.was_quoted),
                           8'(rsp_payload.was_quoted));
               check_field("overflowed", 8'(want.overflowed),
                           8'(rsp_payload.overflowed));
            end
         end
      end
      mismatch_count  <= errors;
      results_pending <= quoted_bytes_due.size();
   end

endmodule

>>> dv/tb_mail_address_quoter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mail address quoter testbench
// Feeds directed and random mail addresses through the quoter, including
// full and overflowing buffers, with random idle cycles on both channels,
// and leaves the checking of every result item to the result checker.
// ----------------------------------------------------------------------------
module tb_mail_address_quoter;
   import maq_pkg::*;

   localparam int ADDR_CAP       = MAX_LEN_DEF;
   localparam int ITEM_TARGET    = 310;
   localparam int PHASE_ONE_END  = 118;
   localparam int PHASE_TWO_END  = 214;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 2 * ADDR_CAP + 8;

   typedef logic [7:0] addr_bytes_type [$];

   typedef enum {
      STYLE_RAW,
      STYLE_CLEAN,
      STYLE_MIXED,
      STYLE_CLEAN_KEPT
   } addr_style_type;

   typedef enum {
      IDLE_SENDER_LIGHT,
      IDLE_RECEIVER_LIGHT,
      IDLE_NONE
   } idle_phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   send_idle_pct = 27;
   int   recv_idle_pct = 46;
   int   items_sent = 0;
   int   quiet_cycles = 0;
   int   check_failures;
   int   results_pending;

   maq_stream_if #(.payload_type(req_payload_type)) req_if ();
   maq_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   mail_address_quoter #(.MAX_LEN(ADDR_CAP)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   maq_result_checker #(.ADDR_CAP(ADDR_CAP)) result_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_if.valid),
      .req_ready       (req_if.ready),
      .req_payload     (req_if.payload),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_payload     (rsp_if.payload),
      .mismatch_count  (check_failures),
      .results_pending (results_pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The result side stalls at random in the share of cycles set per phase.
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Stop the run when neither channel has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Drive one address byte, after a random number of idle cycles.
   task automatic send_item(input logic [7:0] b, input logic is_last);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         if (req_if.valid) begin
            req_if.valid <= 1'b0;
         end
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= '{in_byte: b, in_last: is_last};
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      items_sent++;
   endtask

   task automatic send_address(input addr_bytes_type addr);
      for (int i = 0; i < addr.size(); i++) begin
         send_item(addr[i], i == addr.size() - 1);
      end
   endtask

   // Hold the sender off until every predicted result has come back.
   task automatic hold_until_drained();
      if (req_if.valid) begin
         req_if.valid <= 1'b0;
      end
      @(posedge clock);
      while (results_pending != 0) begin
         @(posedge clock);
      end
   endtask

   // Ordinary address characters that never force quoting.
   function automatic logic [7:0] plain_byte();
      string plain;
      plain = "abcdefghijklmnopqrstuvwxyz0123456789.@-_+=!#ABMZ";
      return plain[$urandom_range(plain.len() - 1)];
   endfunction

   // Whitespace or a byte that needs escaping.
   function automatic logic [7:0] marked_byte();
      case ($urandom_range(11))
         0: return CH_QUOTE;
         1: return CH_BACKSLASH;
         2: return CH_LT;
         3: return CH_GT;
         4: return CH_LPAREN;
         5: return CH_RPAREN;
         6: return CH_SPACE;
         7: return CH_TAB;
         8: return 8'h0A;
         9: return 8'h0B;
         10: return 8'h0C;
         default: return CH_CR;
      endcase
   endfunction

   function automatic addr_bytes_type make_address(input int len,
                                                   input addr_style_type style);
      addr_bytes_type addr;
      logic [7:0]     b;
      for (int i = 0; i < len; i++) begin
         case (style)
            STYLE_RAW:   b = 8'($urandom_range(255));
            STYLE_CLEAN: b = plain_byte();
            STYLE_MIXED: b = ($urandom_range(3) == 0) ? marked_byte() : plain_byte();
            default:     b = (i < ADDR_CAP) ? plain_byte() : marked_byte();
         endcase
         addr.push_back(b);
      end
      return addr;
   endfunction

   // Mostly short addresses, some long ones, a few at or past the buffer size.
   function automatic addr_bytes_type random_address();
      int             pick;
      int             len;
      addr_style_type style;
      pick = $urandom_range(99);
      if (pick < 70) begin
         len = $urandom_range(6, 1);
      end else if (pick < 88) begin
         len = $urandom_range(ADDR_CAP - 1, 7);
      end else if (pick < 93) begin
         len = ADDR_CAP;
      end else begin
         len = $urandom_range(ADDR_CAP + 5, ADDR_CAP + 1);
      end
      pick = $urandom_range(99);
      if (pick < 30) begin
         style = STYLE_RAW;
      end else if (pick < 55) begin
         style = STYLE_CLEAN;
      end else if (pick < 90) begin
         style = STYLE_MIXED;
      end else begin
         style = STYLE_CLEAN_KEPT;
      end
      return make_address(len, style);
   endfunction

   // Reset, directed addresses, then random addresses over three idle phases.
   initial begin
      addr_bytes_type addr;
      idle_phase_type phase;
      idle_phase_type next_phase;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      phase          = IDLE_SENDER_LIGHT;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Lone NUL byte and lone all-ones byte: shortest plain addresses.
      send_item(8'h00, 1'b1);
      send_item(8'hFF, 1'b1);
      // A plain address passes unchanged.
      addr = {8'h78, 8'h40, 8'h79};
      send_address(addr);
      // Every special byte: quoted, each one escaped.
      addr = {CH_QUOTE, CH_BACKSLASH, CH_LT, CH_GT, CH_LPAREN, CH_RPAREN};
      send_address(addr);
      // Every whitespace byte: quoted but nothing escaped.
      addr = {CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR, CH_SPACE};
      send_address(addr);
      // Neighbors of the marked bytes stay plain.
      addr = {8'h08, 8'h0E, 8'h21, 8'h3D, 8'h5B};
      send_address(addr);
      hold_until_drained();

      // A full buffer with no drop, then clean kept bytes with a marked
      // dropped tail, which must not cause quoting.
      addr = make_address(ADDR_CAP, STYLE_CLEAN);
      send_address(addr);
      addr = make_address(ADDR_CAP + 3, STYLE_CLEAN_KEPT);
      send_address(addr);

      while (items_sent < ITEM_TARGET) begin
         if (items_sent < PHASE_ONE_END) begin
            next_phase = IDLE_SENDER_LIGHT;
         end else if (items_sent < PHASE_TWO_END) begin
            next_phase = IDLE_RECEIVER_LIGHT;
         end else begin
            next_phase = IDLE_NONE;
         end
         if (next_phase != phase) begin
            hold_until_drained();
            phase = next_phase;
            if (phase == IDLE_RECEIVER_LIGHT) begin
               send_idle_pct = 46;
               recv_idle_pct = 27;
            end else begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         end
         addr = random_address();
         send_address(addr);
      end

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (check_failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
